/* sv/ftlb_pkg.sv */
package ftlb_pkg;

   localparam int CMD_W    = 2;
   localparam int PAGE_W   = 20;
   localparam int VICTIM_W = 6;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

   // One request walking down the row of entry cells
   typedef struct packed {
      logic                live;
      logic [CMD_W-1:0]    cmd;
      logic [PAGE_W-1:0]   vpage;
      logic [PAGE_W-1:0]   frame;
      logic [VICTIM_W-1:0] victim;
      logic                hit;
      logic [PAGE_W-1:0]   frame_acc;
      logic                placed;
   } token_type;

   // Replacement write broadcast to every cell at the end of a fill walk
   typedef struct packed {
      logic                en;
      logic [VICTIM_W-1:0] victim;
      logic [PAGE_W-1:0]   vpage;
      logic [PAGE_W-1:0]   frame;
   } victim_wr_type;

endpackage

/* sv/ftlb_cell.sv */
module ftlb_cell
   import ftlb_pkg::*;
#(
   parameter int IDX_W      = 6,
   parameter int CELL_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  token_type     tok_in,
   input  victim_wr_type vwr,
   output token_type     tok_out
);

   localparam int WIDE_W = (IDX_W > VICTIM_W) ? IDX_W : VICTIM_W;

   logic              valid_ff, valid_in;
   logic [PAGE_W-1:0] tag_ff;
   logic [PAGE_W-1:0] frame_ff;
   token_type         tok_ff, tok_in_nxt;
   logic              fill_here;
   logic              victim_here;
   logic [WIDE_W-1:0] victim_wide;
   logic [IDX_W-1:0]  victim_idx;

   assign victim_wide = WIDE_W'(vwr.victim);
   assign victim_idx  = victim_wide[IDX_W-1:0];
   assign victim_here = vwr.en && (victim_idx == IDX_W'(CELL_INDEX));
   assign fill_here   = tok_in.live && (tok_in.cmd == CMD_FILL)
                        && !tok_in.placed && !valid_ff;

   always_comb begin
      tok_in_nxt = tok_in;
      if (tok_in.live && (tok_in.cmd == CMD_LOOKUP) && !tok_in.hit
          && valid_ff && (tag_ff == tok_in.vpage)) begin
         tok_in_nxt.hit       = 1'b1;
         tok_in_nxt.frame_acc = frame_ff;
      end
      if (fill_here) begin
         tok_in_nxt.placed = 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (tok_in.live && (tok_in.cmd == CMD_FLUSH)) begin
         valid_in = 1'b0;
      end else if (fill_here || victim_here) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_here) begin
         tag_ff   <= tok_in.vpage;
         frame_ff <= tok_in.frame;
      end else if (victim_here) begin
         tag_ff   <= vwr.vpage;
         frame_ff <= vwr.frame;
      end
   end

   // advance the beat one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* sv/fully_associative_tlb_core.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_cmd, req_virtual_page, req_frame_in,
//                                          req_victim_pick
// rsp      out        rsp_valid/rsp_stall  rsp_hit, rsp_frame_out
//
// Each beat walks the row of 2**ENTRY_INDEX_BITS entry cells, one cell per cycle,
// and its result lands in the output register in the cycle after it leaves the last cell.
// One beat is in the row at a time; the next is taken once the row is empty and
// the output register is empty or being drained.
// Reset clears every valid bit; tags and frames are not reset.
// A stalled result holds in the output register and holds off new requests.
module fully_associative_tlb_core
   import ftlb_pkg::*;
#(
   parameter int ENTRY_INDEX_BITS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [PAGE_W-1:0]   req_virtual_page,
   input  logic [PAGE_W-1:0]   req_frame_in,
   input  logic [VICTIM_W-1:0] req_victim_pick,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [PAGE_W-1:0]   rsp_frame_out
);

   localparam int ENTRIES = 1 << ENTRY_INDEX_BITS;

   token_type         tok_chain [ENTRIES+1];
   logic [ENTRIES-1:0] live_vec;
   victim_wr_type     vwr;
   token_type         last_tok;
   logic              req_accept;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [PAGE_W-1:0] rsp_frame_ff;

   assign req_stall  = busy_ff || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      tok_chain[0].live      = req_accept;
      tok_chain[0].cmd       = req_cmd;
      tok_chain[0].vpage     = req_virtual_page;
      tok_chain[0].frame     = req_frame_in;
      tok_chain[0].victim    = req_victim_pick;
      tok_chain[0].hit       = 1'b0;
      tok_chain[0].frame_acc = '0;
      tok_chain[0].placed    = 1'b0;
   end

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      ftlb_cell #(
         .IDX_W      (ENTRY_INDEX_BITS),
         .CELL_INDEX (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_chain[k]),
         .vwr     (vwr),
         .tok_out (tok_chain[k+1])
      );
      assign live_vec[k] = tok_chain[k+1].live;
   end

   assign last_tok = tok_chain[ENTRIES];

   // no free entry found on the walk: overwrite the picked victim
   always_comb begin
      vwr.en     = last_tok.live && (last_tok.cmd == CMD_FILL) && !last_tok.placed;
      vwr.victim = last_tok.victim;
      vwr.vpage  = last_tok.vpage;
      vwr.frame  = last_tok.frame;
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (last_tok.live) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (last_tok.live) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_tok.live) begin
         rsp_hit_ff   <= last_tok.hit;
         rsp_frame_ff <= last_tok.frame_acc;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_frame_out = rsp_frame_ff;

   a_one_beat_in_row: assert property (@(posedge clock) disable iff (reset)
      $onehot0(live_vec))
      else $error("more than one beat in the cell row");

   a_busy_tracks_row: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (|live_vec))
      else $error("busy flag out of step with the cell row");

   a_last_to_rsp: assert property (@(posedge clock) disable iff (reset)
      last_tok.live |=> rsp_valid_ff)
      else $error("result left the row but no response raised");

   a_miss_zero_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_frame_ff == '0))
      else $error("nonzero frame on a miss");

endmodule
